/* design/alrg_pkg.sv */
// Shared types, constants and helpers of the additive lagged random generator.
package alrg_pkg;

    localparam int DEF_MAX_WORDS = 63;
    localparam int WORDS_W = 6;
    localparam int SEED_W = 32;
    localparam int WORD_W = 32;
    localparam int VALUE_W = 31;
    localparam int MULT_W = 15;
    localparam int PROD_W = WORD_W + MULT_W;
    localparam int CODE_W = 3;

    localparam logic [MULT_W-1:0] LEHMER_MULT = 15'd16807;
    localparam logic [VALUE_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
    localparam logic [CODE_W-1:0] RESET_SIZE_CODE = 3'd3;
    localparam logic [SEED_W-1:0] RESET_SEED = 32'd1;

    localparam logic [CODE_W-1:0] SIZE_1 = 3'd0;
    localparam logic [CODE_W-1:0] SIZE_7 = 3'd1;
    localparam logic [CODE_W-1:0] SIZE_15 = 3'd2;
    localparam logic [CODE_W-1:0] SIZE_31 = 3'd3;

    typedef struct packed {
        logic load_seed;
        logic load_init;
        logic mul;
        logic reduce;
        logic draw_commit;
        logic seed_ack;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
    } t_status;

    function automatic logic [WORDS_W-1:0] words_for_code(input logic [CODE_W-1:0] code);
        logic [WORDS_W-1:0] words;
        unique case (code)
            SIZE_1:  words = 6'd1;
            SIZE_7:  words = 6'd7;
            SIZE_15: words = 6'd15;
            SIZE_31: words = 6'd31;
            default: words = 6'd63;
        endcase
        return words;
    endfunction

endpackage

/* design/alrg_datapath.sv */
// Datapath: word table, indices, Lehmer multiply and reduce, and result register.
module alrg_datapath #(
    parameter int MAX_WORDS = alrg_pkg::DEF_MAX_WORDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  alrg_pkg::t_cmd                i_cmd,
    output alrg_pkg::t_status             o_status,
    input  logic                          i_cfg_we,
    input  logic [alrg_pkg::CODE_W-1:0]   i_cfg_data,
    input  logic [alrg_pkg::SEED_W-1:0]   i_seed,
    output logic [alrg_pkg::VALUE_W-1:0]  o_value,
    output logic                          o_seeded
);
    import alrg_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [WORD_W-1:0]  r_word_mem [MAX_WORDS];
    logic [WORD_W-1:0]  r_rd_wr;
    logic [WORD_W-1:0]  r_rd_lag;
    logic [CODE_W-1:0]  r_size_select;
    logic [CNT_W-1:0]   r_n;
    logic [IDX_W-1:0]   r_wr_idx;
    logic [IDX_W-1:0]   r_lag_idx;
    logic [IDX_W-1:0]   r_fill;
    logic [SEED_W-1:0]  r_lehmer;
    logic [PROD_W-1:0]  r_prod;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_seeded;

    logic [CNT_W-1:0]   w_n_sel;
    logic [CODE_W-1:0]  w_code_sel;
    logic [WORD_W-1:0]  w_red_sum;
    logic [VALUE_W-1:0] w_red;
    logic [WORD_W-1:0]  w_draw_sum;
    logic [CNT_W-1:0]   w_wr_inc;
    logic [CNT_W-1:0]   w_lag_inc;
    logic [CNT_W-1:0]   w_fill_inc;
    logic               w_mem_we;
    logic [IDX_W-1:0]   w_mem_addr;
    logic [WORD_W-1:0]  w_mem_data;

    function automatic logic [CNT_W-1:0] clamp_words(input logic [CODE_W-1:0] code);
        logic [WORDS_W-1:0] words;
        words = words_for_code(code);
        if (int'(words) > MAX_WORDS) begin
            return CNT_W'(MAX_WORDS);
        end
        return CNT_W'(words);
    endfunction

    always_comb begin
        w_code_sel = i_cmd.load_init ? RESET_SIZE_CODE : r_size_select;
        w_n_sel = clamp_words(w_code_sel);
        w_red_sum = WORD_W'(r_prod[PROD_W-1:VALUE_W]) + WORD_W'(r_prod[VALUE_W-1:0]);
        if (w_red_sum >= {1'b0, LEHMER_MOD}) begin
            w_red = VALUE_W'(w_red_sum - {1'b0, LEHMER_MOD});
        end else begin
            w_red = VALUE_W'(w_red_sum);
        end
        w_draw_sum = r_rd_wr + r_rd_lag;
        w_wr_inc = CNT_W'(r_wr_idx) + CNT_W'(1);
        w_lag_inc = CNT_W'(r_lag_idx) + CNT_W'(1);
        w_fill_inc = CNT_W'(r_fill) + CNT_W'(1);
        w_mem_we = i_cmd.reduce || i_cmd.draw_commit;
        w_mem_addr = i_cmd.reduce ? r_fill : r_wr_idx;
        w_mem_data = i_cmd.reduce ? {1'b0, w_red} : w_draw_sum;
    end

    assign o_status.fill_last = (w_fill_inc == r_n);
    assign o_value = r_out_value;
    assign o_seeded = r_out_seeded;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_word_mem[w_mem_addr] <= w_mem_data;
        end
        r_rd_wr <= r_word_mem[r_wr_idx];
        r_rd_lag <= r_word_mem[r_lag_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_select <= RESET_SIZE_CODE;
            r_n <= clamp_words(RESET_SIZE_CODE);
            r_wr_idx <= '0;
            r_lag_idx <= IDX_W'(clamp_words(RESET_SIZE_CODE) - CNT_W'(1));
            r_fill <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size_select <= i_cfg_data;
            end
            if (i_cmd.load_seed || i_cmd.load_init) begin
                r_n <= w_n_sel;
                r_wr_idx <= '0;
                r_lag_idx <= IDX_W'(w_n_sel - CNT_W'(1));
                r_fill <= '0;
            end else if (i_cmd.reduce) begin
                r_fill <= IDX_W'(w_fill_inc);
            end else if (i_cmd.draw_commit) begin
                r_wr_idx <= (w_wr_inc == r_n) ? '0 : IDX_W'(w_wr_inc);
                r_lag_idx <= (w_lag_inc == r_n) ? '0 : IDX_W'(w_lag_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_init) begin
            r_lehmer <= RESET_SEED;
        end else if (i_cmd.load_seed) begin
            r_lehmer <= i_seed;
        end else if (i_cmd.reduce) begin
            r_lehmer <= {1'b0, w_red};
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_lehmer) * PROD_W'(LEHMER_MULT);
        end
        if (i_cmd.draw_commit) begin
            r_out_value <= w_draw_sum[WORD_W-1:1];
            r_out_seeded <= 1'b0;
        end else if (i_cmd.seed_ack) begin
            r_out_value <= '0;
            r_out_seeded <= 1'b1;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_wr_idx) < r_n) && (CNT_W'(r_lag_idx) < r_n))
        else $error("table index beyond active size");

    a_lag_trails_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_lag_inc == r_n) ? '0 : IDX_W'(w_lag_inc)) == r_wr_idx)
        else $error("lag index does not trail write index by one");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.reduce |-> (CNT_W'(r_fill) < r_n))
        else $error("fill beyond active size");

endmodule

/* design/alrg_ctrl.sv */
// Controller: sequences draws, reseed fills and the reset fill, and holds result valid.
module alrg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_func,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output alrg_pkg::t_cmd      o_cmd,
    input  alrg_pkg::t_status   i_status
);
    import alrg_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RED  = 3'd3;
    localparam logic [2:0] S_DRAW = 3'd4;
    localparam logic [2:0] S_ACK  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_init;
    logic       n_init;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;
    logic       w_accept;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_init = r_init;
        o_cmd = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.load_init = 1'b1;
                n_state = S_MUL;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func) begin
                        o_cmd.load_seed = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_RED;
            end
            S_RED: begin
                o_cmd.reduce = 1'b1;
                if (i_status.fill_last) begin
                    n_init = 1'b0;
                    n_state = r_init ? S_IDLE : S_ACK;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DRAW: begin
                if (w_out_free) begin
                    o_cmd.draw_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ACK: begin
                if (w_out_free) begin
                    o_cmd.seed_ack = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (o_cmd.draw_commit || o_cmd.seed_ack) ? 1'b1
                    : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    a_draw_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_func) |=> (r_state == S_DRAW))
        else $error("draw request did not enter draw state");

    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.draw_commit || o_cmd.seed_ack))
        else $error("result valid without a commit");

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_in_ready)
        else $error("request accepted during reset fill");

    a_reset_fill_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !(o_cmd.draw_commit || o_cmd.seed_ack))
        else $error("result produced by reset fill");

endmodule

/* design/additive_lagged_random_generator.sv */
// Top level of the additive lagged random generator with Lehmer reseeding.
// Draw: a taken request enters the draw state, which registers the result. Reseed: the
// Lehmer multiply-and-reduce loop fills the N-word table from the seed, with a multiply
// and a reduce state per word, and the ack state registers the result. Requests are taken
// only when idle. A new request is taken while a result waits; a held result stalls it.
// Reset: synchronous; afterwards a 31-word fill from seed 1 keeps tready low.
module additive_lagged_random_generator #(
    parameter int MAX_WORDS = alrg_pkg::DEF_MAX_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,        // size_select
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // [31:0] seed
    input  logic [0:0]  i_s_axis_tuser,    // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,    // [30:0] value, [31] zero
    output logic [0:0]  o_m_axis_tuser     // [0] seeded
);
    import alrg_pkg::*;

    t_cmd               w_cmd;
    t_status            w_status;
    logic [VALUE_W-1:0] w_value;
    logic               w_seeded;

    alrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_func      (i_s_axis_tuser[0]),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    alrg_datapath #(
        .MAX_WORDS (MAX_WORDS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_seed     (i_s_axis_tdata),
        .o_value    (w_value),
        .o_seeded   (w_seeded)
    );

    assign o_m_axis_tdata = {1'b0, w_value};
    assign o_m_axis_tuser = w_seeded;

endmodule
